/* rtl/lcdsfw_pkg.sv */
package lcdsfw_pkg;

  // Request codes.
  localparam logic [1:0] REQ_CMD  = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_NUM  = 2'd2;

  // Register indices of the configuration port.
  localparam logic CFG_SEG_LO = 1'b0;
  localparam logic CFG_SEG_HI = 1'b1;

  // Frame identifiers, sent first in every frame.
  localparam logic [2:0] ID_CMD   = 3'b100;
  localparam logic [2:0] ID_WRITE = 3'b101;

  localparam int unsigned NumW      = 16;  // binary value width
  localparam int unsigned NumDigits = 5;   // decimal digits shown
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned CntW      = 5;   // holds NumW

  localparam int unsigned FrameBits = 49;  // longest frame
  localparam int unsigned FrameCntW = 6;   // holds FrameBits

  localparam logic [FrameCntW-1:0] LenCmd  = FrameCntW'(12);
  localparam logic [FrameCntW-1:0] LenData = FrameCntW'(13);
  localparam logic [FrameCntW-1:0] LenNum  = FrameCntW'(FrameBits);

  // Frame handed to the shifter, left aligned so the first bit is the MSB.
  typedef struct packed {
    logic                 load;
    logic [FrameBits-1:0] bits;
    logic [FrameCntW-1:0] len;
  } frame_load_t;

  // Segment code of one decimal digit from the two table registers.
  function automatic logic [7:0] seg_code(input logic [3:0]  digit,
                                          input logic [63:0] tab_lo,
                                          input logic [15:0] tab_hi);
    logic [7:0] code;
    code = 8'h00;
    if (digit[3] == 1'b0) begin
      code = tab_lo[{digit[2:0], 3'b000} +: 8];
    end else if (digit == 4'd8) begin
      code = tab_hi[7:0];
    end else if (digit == 4'd9) begin
      code = tab_hi[15:8];
    end
    return code;
  endfunction

endpackage

/* rtl/lcdsfw_bin2bcd.sv */
module lcdsfw_bin2bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lcdsfw_pkg::NumW-1:0]   value_i,
  output logic                          done_o,
  output logic [lcdsfw_pkg::BcdW-1:0]   bcd_o
);
  import lcdsfw_pkg::*;

  logic [NumW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [BcdW-1:0] bcd_adj;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  // Shift-and-add-three: one binary bit enters bcd_q each busy cycle.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[NumW-1]};
      bin_d = {bin_q[NumW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

/* rtl/lcdsfw_frame_shifter.sv */
module lcdsfw_frame_shifter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lcdsfw_pkg::frame_load_t frame_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    serial_bit_o,
  output logic                    frame_last_o
);
  import lcdsfw_pkg::*;

  logic [FrameBits-1:0] sh_q, sh_d;
  logic [FrameCntW-1:0] cnt_q, cnt_d;
  logic                 valid_q, valid_d;
  logic                 take;

  assign take = valid_q && !out_stall_i;

  always_comb begin
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    if (frame_i.load) begin
      sh_d    = frame_i.bits;
      cnt_d   = frame_i.len;
      valid_d = 1'b1;
    end else if (take) begin
      sh_d    = {sh_q[FrameBits-2:0], 1'b0};
      cnt_d   = cnt_q - FrameCntW'(1);
      valid_d = (cnt_q != FrameCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign out_valid_o  = valid_q;
  assign serial_bit_o = sh_q[FrameBits-1];
  assign frame_last_o = (cnt_q == FrameCntW'(1));

endmodule

/* rtl/lcd_controller_serial_frame_writer_core.sv */
// Serial frame writer for a three-wire segment LCD controller. Each accepted
// command, data or number request becomes one chip-select frame, sent most
// significant bit first as one output word per serial bit, with frame_last_o
// flagging the bit after which chip select is released. A command frame
// (request type 0) is 12 bits, a nibble data write (type 1) is 13 bits and a
// number display (type 2) is 49 bits; request type 3 is accepted and produces
// nothing. The block works on one request at a time and holds in_stall_o high
// until the last bit of the frame has been taken. A number display goes
// through bit-serial binary to decimal conversion, a lookup of the five
// segment codes and the serial bits, and after the last bit the block returns
// to idle before it takes the next request. The output shift register moves
// one bit per cycle while the output is not stalled, and output stall delays
// the frame. The segment table registers are written through the cfg port;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Both reset to zero.
module lcd_controller_serial_frame_writer_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  command_byte_i,
  input  logic [5:0]  ram_address_i,
  input  logic [3:0]  data_nibble_i,
  input  logic [15:0] number_value_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        serial_bit_o,
  output logic        frame_last_o
);
  import lcdsfw_pkg::*;

  // Control states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [63:0] seg_lo_q;
  logic [15:0] seg_hi_q;

  logic            in_take;
  logic            out_take;
  logic            conv_start;
  logic            conv_done;
  logic [BcdW-1:0] bcd;
  frame_load_t     frame;
  logic [8*NumDigits-1:0] seg_bits;

  // Segment table registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_lo_q <= '0;
      seg_hi_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SEG_LO) begin
        seg_lo_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_SEG_HI) begin
        seg_hi_q <= cfg_data_i[15:0];
      end
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_o && !out_stall_i;
  assign conv_start = in_take && (req_type_i == REQ_NUM);

  // The leading digit is highest in the BCD word and is sent first.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      seg_bits[8*i +: 8] = seg_code(bcd[4*i +: 4], seg_lo_q, seg_hi_q);
    end
  end

  // Frame assembly: commands and data writes load straight from the request,
  // number displays once the decimal digits are ready.
  always_comb begin
    frame.load = 1'b0;
    frame.bits = '0;
    frame.len  = LenCmd;
    if (state_q == ST_CONV) begin
      frame.load = conv_done;
      frame.bits = {ID_WRITE, 6'b000000, seg_bits};
      frame.len  = LenNum;
    end else if (in_take && (req_type_i == REQ_CMD)) begin
      frame.load = 1'b1;
      frame.bits = {ID_CMD, command_byte_i, 1'b0, (FrameBits-12)'(0)};
      frame.len  = LenCmd;
    end else if (in_take && (req_type_i == REQ_DATA)) begin
      frame.load = 1'b1;
      frame.bits = {ID_WRITE, ram_address_i, data_nibble_i, (FrameBits-13)'(0)};
      frame.len  = LenData;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (conv_start) begin
          state_d = ST_CONV;
        end else if (frame.load) begin
          state_d = ST_SEND;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_take && frame_last_o) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  lcdsfw_bin2bcd u_bin2bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (number_value_i),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  lcdsfw_frame_shifter u_shifter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .serial_bit_o (serial_bit_o),
    .frame_last_o (frame_last_o)
  );

`ifndef NO_ASSERTIONS
  // Nothing is sent while the block is open for a new request.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("output word valid while idle");

  // No bit leaves during the decimal conversion.
  a_conv_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !out_valid_o)
    else $error("output word valid during conversion");

  // Once the last bit is taken the frame is over and the block is idle.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && frame_last_o) |=> (!out_valid_o && !in_stall_o))
    else $error("frame did not end after its last bit");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  import lcdsfw_pkg::*;

  // Request code that the block accepts and then drops without sending a frame.
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Settling wait that covers anything the block might still be doing once
  // the last bit has left.
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cmd;
    logic [5:0]  addr;
    logic [3:0]  nib;
    logic [15:0] num;
  } req_word_t;

  typedef struct packed {
    logic level;
    logic last;
  } line_bit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_SEG_LO;
  logic [63:0] cfg_data_i = '0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = REQ_CMD;
  logic [7:0]  command_byte_i = '0;
  logic [5:0]  ram_address_i = '0;
  logic [3:0]  data_nibble_i = '0;
  logic [15:0] number_value_i = '0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        serial_bit_o;
  logic        frame_last_o;

  // Request words waiting to be offered, and the line bits still owed by the block.
  req_word_t   pending_req_q[$];
  line_bit_t   line_bits_q[$];

  // Local copy of the segment table registers.
  logic [63:0] seg_tab_lo;
  logic [15:0] seg_tab_hi;

  // Percentage of cycles in which the sender idles and the receiver stalls.
  int unsigned gap_pct = 14;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  lcd_controller_serial_frame_writer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .command_byte_i (command_byte_i),
    .ram_address_i  (ram_address_i),
    .data_nibble_i  (data_nibble_i),
    .number_value_i (number_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .serial_bit_o   (serial_bit_o),
    .frame_last_o   (frame_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Segment code of one decimal digit, looked up in the local table copy.
  function automatic logic [7:0] digit_code(input int unsigned digit);
    logic [7:0] code;
    case (digit)
      8: code = seg_tab_hi[7:0];
      9: code = seg_tab_hi[15:8];
      default: code = seg_tab_lo[8*digit +: 8];
    endcase
    return code;
  endfunction

  // Works out the line bits of the frame that one request word produces, most
  // significant bit first, and appends them to the queue of owed bits. The
  // frame is built left aligned in a 49-bit vector; unused request words give
  // nothing.
  task automatic predict_frame(input req_word_t w);
    logic [48:0] frame;
    int unsigned len;
    int unsigned v;
    line_bit_t   b;
    frame = '0;
    len = 0;
    v = 32'(w.num);
    case (w.kind)
      REQ_CMD: begin
        frame[48 -: 12] = {ID_CMD, w.cmd, 1'b0};
        len = 12;
      end
      REQ_DATA: begin
        frame[48 -: 13] = {ID_WRITE, w.addr, w.nib};
        len = 13;
      end
      REQ_NUM: begin
        // Five digits always go out, leading zeros included; values from
        // 10000 upwards give a leading digit between one and six.
        frame = {ID_WRITE, 6'b000000,
                 digit_code(v / 10000), digit_code((v / 1000) % 10),
                 digit_code((v / 100) % 10), digit_code((v / 10) % 10),
                 digit_code(v % 10)};
        len = 49;
      end
      default: len = 0;
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      b.level = frame[48 - i];
      b.last  = (i == len - 1);
      line_bits_q.push_back(b);
    end
  endtask

  // Keeps the table copy in step with the configuration port and predicts the
  // frame of every request word at the edge where it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_tab_lo = '0;
      seg_tab_hi = '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SEG_LO) begin
          seg_tab_lo = cfg_data_i;
        end else begin
          seg_tab_hi = cfg_data_i[15:0];
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_frame('{kind: req_type_i, cmd: command_byte_i, addr: ram_address_i,
                        nib: data_nibble_i, num: number_value_i});
      end
    end
  end

  // Sender. A new word is offered only once the previous one has gone, so a
  // stalled word stays put; between words the sender idles at random.
  always @(posedge clk_i or negedge rst_ni) begin
    req_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_req_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
        w = pending_req_q.pop_front();
        req_type_i     <= w.kind;
        command_byte_i <= w.cmd;
        ram_address_i  <= w.addr;
        data_nibble_i  <= w.nib;
        number_value_i <= w.num;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver. Every accepted line bit is checked against the oldest owed bit.
  always @(posedge clk_i or negedge rst_ni) begin
    line_bit_t exp_bit;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (line_bits_q.size() == 0) begin
          $error("unexpected word: serial_bit %0b frame_last %0b", serial_bit_o, frame_last_o);
          err_cnt++;
        end else begin
          exp_bit = line_bits_q.pop_front();
          if (serial_bit_o !== exp_bit.level) begin
            $error("serial_bit: expected %0b, got %0b", exp_bit.level, serial_bit_o);
            err_cnt++;
          end
          if (frame_last_o !== exp_bit.last) begin
            $error("frame_last: expected %0b, got %0b", exp_bit.last, frame_last_o);
            err_cnt++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < gap_pct);
    end
  end

  // The run is ended if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Holds off until every queued word has been taken and every owed bit has
  // arrived, then lets the block settle so the table may be rewritten safely.
  // The check is made on the falling edge, once the sender and receiver have
  // both finished their work for the cycle.
  task automatic wait_idle();
    while (pending_req_q.size() > 0 || in_valid_i || line_bits_q.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_req(input logic [1:0] kind, input logic [7:0] cmd,
                           input logic [5:0] addr, input logic [3:0] nib,
                           input logic [15:0] num);
    pending_req_q.push_back('{kind: kind, cmd: cmd, addr: addr, nib: nib, num: num});
  endtask

  // Random request words: mostly well-formed frames of all three kinds, with
  // the odd unused request code thrown in. Every field is random, so the
  // fields a request ignores carry noise as well.
  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    logic [1:0]  kind;
    logic [15:0] num;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 25) kind = REQ_CMD;
      else if (pick < 50) kind = REQ_DATA;
      else if (pick < 90) kind = REQ_NUM;
      else kind = REQ_NONE;
      // A share of small values so that leading zero digits turn up often.
      num = ($urandom_range(3) == 0) ? 16'($urandom_range(999)) : 16'($urandom_range(65535));
      queue_req(kind, 8'($urandom_range(255)), 6'($urandom_range(63)),
                4'($urandom_range(15)), num);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the table still at its reset value every segment code is zero.
    queue_req(REQ_NUM, 8'h00, 6'h00, 4'h0, 16'd12345);
    queue_req(REQ_CMD, 8'hC3, 6'h00, 4'h0, 16'd0);
    wait_idle();

    // Proper seven-segment codes, one distinct byte per digit.
    write_reg(CFG_SEG_LO, 64'h077D_6D66_4F5B_063F);
    write_reg(CFG_SEG_HI, 64'h0000_0000_0000_6F7F);

    // Directed words: field extremes, every request kind, ignored fields
    // driven to all ones, the unused request code, and number values around
    // the decade boundaries including the largest leading digit.
    queue_req(REQ_CMD, 8'h00, 6'h00, 4'h0, 16'h0000);
    queue_req(REQ_CMD, 8'hFF, 6'h3F, 4'hF, 16'hFFFF);
    queue_req(REQ_CMD, 8'h5A, 6'h00, 4'h0, 16'h0000);
    queue_req(REQ_DATA, 8'h00, 6'h00, 4'h0, 16'h0000);
    queue_req(REQ_DATA, 8'hFF, 6'h3F, 4'hF, 16'hFFFF);
    queue_req(REQ_DATA, 8'h00, 6'h15, 4'hA, 16'h0000);
    queue_req(REQ_NONE, 8'hFF, 6'h3F, 4'hF, 16'hFFFF);
    queue_req(REQ_NUM, 8'h00, 6'h00, 4'h0, 16'd0);
    queue_req(REQ_NUM, 8'hFF, 6'h3F, 4'hF, 16'd65535);
    queue_req(REQ_NUM, 8'h00, 6'h00, 4'h0, 16'd9999);
    queue_req(REQ_NUM, 8'h00, 6'h00, 4'h0, 16'd10000);
    queue_req(REQ_NUM, 8'h00, 6'h00, 4'h0, 16'd1);
    queue_req(REQ_NUM, 8'h00, 6'h00, 4'h0, 16'd98);
    queue_req(REQ_NUM, 8'h00, 6'h00, 4'h0, 16'd60000);
    queue_req(REQ_NUM, 8'h00, 6'h00, 4'h0, 16'd40789);
    queue_req(REQ_NONE, 8'h00, 6'h00, 4'h0, 16'h0000);
    queue_req(REQ_NUM, 8'h00, 6'h00, 4'h0, 16'd23456);
    queue_req(REQ_CMD, 8'h81, 6'h2A, 4'h5, 16'hAAAA);
    wait_idle();

    // Table at its upper extreme; the upper bits of the second write are
    // beyond the register and must be dropped.
    write_reg(CFG_SEG_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_SEG_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_random(33);
    wait_idle();

    // Random table, and a long stretch with neither idling nor stall.
    write_reg(CFG_SEG_LO, {32'($urandom), 32'($urandom)});
    write_reg(CFG_SEG_HI, {32'($urandom), 32'($urandom)});
    gap_pct = 0;
    queue_random(33);
    wait_idle();
    gap_pct = 14;

    // Low table back to zero with a random high table.
    write_reg(CFG_SEG_LO, 64'h0);
    write_reg(CFG_SEG_HI, 64'($urandom_range(65535)));
    queue_random(33);
    wait_idle();

    write_reg(CFG_SEG_LO, {32'($urandom), 32'($urandom)});
    write_reg(CFG_SEG_HI, 64'($urandom_range(65535)));
    queue_random(33);
    wait_idle();

    if (line_bits_q.size() != 0) begin
      $error("%0d line bits never arrived", line_bits_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lcdsfw_pkg.sv
rtl/lcdsfw_bin2bcd.sv
rtl/lcdsfw_frame_shifter.sv
rtl/lcd_controller_serial_frame_writer_core.sv
sim/tb_top.sv
